// ----- rtl/gefu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gefu_pkg: shared types and constants for the Gray encoder angle fusion
// Field widths, limits of the sector correction and the register map.
// ----------------------------------------------------------------------------
package gefu_pkg;

  // field widths
  localparam int SAMPLE_W   = 12;
  localparam int ANGLE_W    = 9;
  localparam int SECTION_W  = 4;
  localparam int SECTOR_W   = 3;
  localparam int FINAL_W    = 12;
  localparam int CHANNELS   = 4;

  // default compare width of the reflectance samples
  localparam int SAMPLE_BITS_DEF = 12;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_THRESHOLD = 1'b0;   // word select paddr[2]
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2048;

  // sector correction
  localparam logic [ANGLE_W-1:0]   ANGLE_BACK_LIMIT   = 9'd270;
  localparam logic [ANGLE_W-1:0]   ANGLE_FWD_LIMIT    = 9'd50;
  localparam logic [SECTION_W-1:0] SECTION_FIRST      = 4'd0;
  localparam logic [SECTION_W-1:0] SECTION_LAST       = 4'd15;
  localparam logic [SECTOR_W-1:0]  SECTOR_FIRST       = 3'd0;
  localparam logic [SECTOR_W-1:0]  SECTOR_LAST        = 3'd7;
  localparam logic [FINAL_W-1:0]   EIGHTHS_PER_SECTOR = 12'd360;

  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_vec_t;

  typedef struct packed {
    logic [SECTION_W-1:0] raw_section;
    logic [SECTOR_W-1:0]  sector;
    logic [FINAL_W-1:0]   final_angle;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/gefu_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gefu_decode: threshold slicer and Gray decoder
// Slices the four reflectance samples against the threshold and turns the
// Gray code into the binary section.
// ----------------------------------------------------------------------------
module gefu_decode
  import gefu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire sample_vec_t          samples,
  input  wire logic [SAMPLE_W-1:0]  threshold,
  output logic      [SECTION_W-1:0] section
);

  // samples are compared on their low bits only
  localparam int CMP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  logic [CHANNELS-1:0] gray;

  // strictly above threshold reads as one; channel 3 is the MSB
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      gray[i] = samples[i][CMP_BITS-1:0] > threshold[CMP_BITS-1:0];
    end
  end

  // Gray to binary: each bit is the parity of the Gray bits at and above it
  always_comb begin
    section[SECTION_W-1] = gray[CHANNELS-1];
    for (int i = SECTION_W-2; i >= 0; i--) begin
      section[i] = section[i+1] ^ gray[i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gefu_sector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gefu_sector: sector correction and angle fusion
// Moves the section into a 45-degree sector using the fine angle and forms
// the combined angle in eighths of a degree.
// ----------------------------------------------------------------------------
module gefu_sector
  import gefu_pkg::*;
(
  input  wire logic [SECTION_W-1:0] section,
  input  wire logic [ANGLE_W-1:0]   angle,
  output result_t                   result
);

  logic [SECTOR_W-1:0] sector;
  logic                step_back;
  logic                step_fwd;

  // even section late in the turn belongs to the previous sector,
  // odd section early in the turn to the next one
  assign step_back = !section[0] && (angle > ANGLE_BACK_LIMIT);
  assign step_fwd  =  section[0] && (angle < ANGLE_FWD_LIMIT);

  always_comb begin
    priority if (step_back) begin
      if (section == SECTION_FIRST) begin
        sector = SECTOR_LAST;
      end else begin
        sector = section[SECTION_W-1:1] - SECTOR_W'(1);
      end
    end else if (step_fwd) begin
      if (section == SECTION_LAST) begin
        sector = SECTOR_FIRST;
      end else begin
        sector = section[SECTION_W-1:1] + SECTOR_W'(1);
      end
    end else begin
      sector = section[SECTION_W-1:1];
    end
  end

  // angle + 360 * sector, constant multiply on a 3-bit value
  assign result.raw_section = section;
  assign result.sector      = sector;
  assign result.final_angle = FINAL_W'(angle) + FINAL_W'(EIGHTHS_PER_SECTOR * FINAL_W'(sector));

endmodule
`default_nettype wire

// ----- rtl/gray_encoder_angle_fusion.sv -----
`default_nettype none
// Path: a result passes the input register, then the result register, where it
// waits while out_ready is low.
// Throughput: one item per cycle while out_ready is high; the compare, Gray decode
// and sector correction sit in one short combinational path between the two registers.
// Reset (rst_n low, synchronous): both stages empty, threshold = 2048.
// ----------------------------------------------------------------------------
// gray_encoder_angle_fusion: Gray encoder coarse/fine angle fusion
// Fuses a Gray-coded reflectance section with a magnetic fine angle.
// ----------------------------------------------------------------------------
module gray_encoder_angle_fusion
  import gefu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   in_sample_ch0,
  input  wire logic [SAMPLE_W-1:0]   in_sample_ch1,
  input  wire logic [SAMPLE_W-1:0]   in_sample_ch2,
  input  wire logic [SAMPLE_W-1:0]   in_sample_ch3,
  input  wire logic [ANGLE_W-1:0]    in_mag_angle,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [SECTION_W-1:0]  out_raw_section,
  output logic      [SECTOR_W-1:0]   out_sector,
  output logic      [FINAL_W-1:0]    out_final_angle
);

  logic [SAMPLE_W-1:0] threshold_r;
  logic                cfg_wr;

  logic                s1_valid_r;
  sample_vec_t         s1_samples_r;
  logic [ANGLE_W-1:0]  s1_angle_r;
  logic                out_valid_r;
  result_t             res_r;

  logic                res_load;
  logic                s1_load;
  logic [SECTION_W-1:0] section;
  result_t             result;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      threshold_r <= pwdata[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (psel && (paddr[2] == REG_THRESHOLD)) begin
      prdata = APB_DATA_W'(threshold_r);
    end
  end

  // pipeline flow: result register frees when empty or taken
  assign res_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || res_load;
  assign s1_load  = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_samples_r <= {in_sample_ch3, in_sample_ch2, in_sample_ch1, in_sample_ch0};
      s1_angle_r   <= in_mag_angle;
    end
  end

  // decode and fuse
  gefu_decode #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_decode (
    .samples   (s1_samples_r),
    .threshold (threshold_r),
    .section   (section)
  );

  gefu_sector u_sector (
    .section (section),
    .angle   (s1_angle_r),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_raw_section = res_r.raw_section;
  assign out_sector      = res_r.sector;
  assign out_final_angle = res_r.final_angle;

endmodule
`default_nettype wire
